/* hw/rtl/min_heap_priority_queue_defines.svh */
// assertion macros for the min-heap priority queue
// used by the top level, no other dependencies
`ifndef MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define MHPQ_ASSERT_IMPL(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("mhpq check failed");

// next-cycle implication
`define MHPQ_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("mhpq check failed");

`endif

/* hw/rtl/mhpq_pkg.sv */
// shared constants, types and codes of the min-heap priority queue
// no dependencies
package mhpq_pkg;

  localparam int HEAP_DEPTH  = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(HEAP_DEPTH);
  localparam int COUNT_W     = $clog2(HEAP_DEPTH + 1);
  localparam int IDX_W       = ADDR_W + 2;
  localparam int TOP_W       = 32;
  localparam int ENTRY_W     = 9;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [TOP_W-1:0]              top_t;

  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] push_value;
  } req_t;

  typedef struct packed {
    top_t               top_value;
    logic [ENTRY_W-1:0] entry_count;
    logic               is_empty;
    status_t            status;
  } res_t;

endpackage

/* hw/rtl/mhpq_if.sv */
// request and response channel interfaces of the min-heap priority queue
// no dependencies
interface mhpq_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink (input valid, input req_type, input push_value, output ready);
endinterface

interface mhpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] top_value;
  logic [8:0]  entry_count;
  logic        is_empty;
  logic [1:0]  status;

  modport source (output valid, output top_value, output entry_count, output is_empty,
                  output status, input ready);
  modport sink (input valid, input top_value, input entry_count, input is_empty,
                input status, output ready);
endinterface

/* hw/rtl/mhpq_heap.sv */
// heap store and sift sequencer of the min-heap priority queue
// depends on mhpq_pkg
module mhpq_heap import mhpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] count;
  logic [ADDR_W-1:0]  pos;
  value_t             cur;
  value_t             root;
  status_t            status;

  value_t mem [HEAP_DEPTH];
  value_t rd0;
  value_t rd1;

  logic [ADDR_W-1:0] rd_addr0;
  logic [ADDR_W-1:0] rd_addr1;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  value_t            wr_data;

  logic [ADDR_W-1:0] parent;
  logic [IDX_W-1:0]  left_idx;
  logic [IDX_W-1:0]  right_idx;
  logic [IDX_W-1:0]  cnt_idx;
  logic              has_left;
  logic              has_right;
  logic              take_right;
  value_t            child_val;
  logic [ADDR_W-1:0] child_pos;

  assign parent     = (pos - ADDR_W'(1)) >> 1;
  assign left_idx   = {1'b0, pos, 1'b1};
  assign right_idx  = left_idx + IDX_W'(1);
  assign cnt_idx    = IDX_W'(count);
  assign has_left   = left_idx < cnt_idx;
  assign has_right  = right_idx < cnt_idx;
  assign take_right = has_right && (rd1 < rd0);
  assign child_val  = take_right ? rd1 : rd0;
  assign child_pos  = take_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

  always_comb begin
    rd_addr0 = '0;
    rd_addr1 = '0;
    wr_en    = 1'b0;
    wr_addr  = pos;
    wr_data  = cur;
    unique case (state)
      S_UP_RD: begin
        if (pos == '0) begin
          wr_en = 1'b1;
        end else begin
          rd_addr0 = parent;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rd0 > cur) begin
          wr_data = rd0;
        end
      end
      S_DN_LAST: begin
        rd_addr0 = ADDR_W'(count);
      end
      S_DN_RD: begin
        rd_addr0 = left_idx[ADDR_W-1:0];
        rd_addr1 = right_idx[ADDR_W-1:0];
        if (!has_left) begin
          wr_en = 1'b1;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (cur > child_val) begin
          wr_data = child_val;
        end
      end
      S_IDLE, S_DN_LOAD, S_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0 <= mem[rd_addr0];
    rd1 <= mem[rd_addr1];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == '0) begin
      root <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      status <= ST_OK;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.req_type == REQ_PUSH) begin
              if (count == COUNT_W'(HEAP_DEPTH)) begin
                status <= ST_FULL;
                state  <= S_DONE;
              end else begin
                status <= ST_OK;
                pos    <= ADDR_W'(count);
                cur    <= value_t'(req.push_value);
                count  <= count + COUNT_W'(1);
                state  <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                status <= ST_EMPTY;
                state  <= S_DONE;
              end else begin
                status <= ST_OK;
                count  <= count - COUNT_W'(1);
                state  <= (count == COUNT_W'(1)) ? S_DONE : S_DN_LAST;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= (pos == '0) ? S_DONE : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (rd0 > cur) begin
            pos   <= parent;
            state <= S_UP_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_LAST: begin
          state <= S_DN_LOAD;
        end
        S_DN_LOAD: begin
          cur   <= rd0;
          pos   <= '0;
          state <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= has_left ? S_DN_CMP : S_DONE;
        end
        S_DN_CMP: begin
          if (cur > child_val) begin
            pos   <= child_pos;
            state <= S_DN_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign req_ready       = (state == S_IDLE);
  assign res_valid       = (state == S_DONE);
  assign res.top_value   = (count == '0) ? '0 : top_t'(root);
  assign res.entry_count = ENTRY_W'(count);
  assign res.is_empty    = (count == '0);
  assign res.status      = status;

endmodule

/* hw/rtl/min_heap_priority_queue.sv */
// steps, accepting edge to rsp.valid: a push sifts the new value up from the end slot,
// reading and comparing the parent per level; a pop loads the last entry at the root and
// sifts down, comparing both children per level; a reject or a pop of the last entry
// skips the sift; one item at a time: no new request until the output register takes the result
// reset: entry count cleared, no item pending; heap memory contents undefined
// top level, depends on mhpq_pkg, mhpq_if, mhpq_heap and the defines header
`include "min_heap_priority_queue_defines.svh"

module min_heap_priority_queue import mhpq_pkg::*; (
  input logic     clk,
  input logic     rst,
  mhpq_req_if.sink   req,
  mhpq_rsp_if.source rsp
);

  req_t core_req;
  logic core_req_ready;
  logic core_res_valid;
  logic core_res_ready;
  res_t core_res;

  logic out_valid;
  res_t out_res;

  assign core_req.req_type   = req_type_t'(req.req_type);
  assign core_req.push_value = req.push_value;

  mhpq_heap u_heap (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (core_req_ready),
    .req       (core_req),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res)
  );

  assign req.ready      = core_req_ready;
  assign core_res_ready = !out_valid || rsp.ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_res_ready) begin
      out_valid <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_ready && core_res_valid) begin
      out_res <= core_res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.top_value   = out_res.top_value;
  assign rsp.entry_count = out_res.entry_count;
  assign rsp.is_empty    = out_res.is_empty;
  assign rsp.status      = out_res.status;

  `MHPQ_ASSERT_IMPL(a_count_range, clk, rst, core_res_valid, core_res.entry_count <= ENTRY_W'(HEAP_DEPTH))
  `MHPQ_ASSERT_IMPL(a_reject_empty, clk, rst, core_res_valid && core_res.status == ST_EMPTY, core_res.is_empty && core_res.top_value == '0)
  `MHPQ_ASSERT_IMPL(a_no_accept_with_result, clk, rst, core_res_valid, !core_req_ready)
  `MHPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && core_req_ready, !core_req_ready)

endmodule

/* test/tb_min_heap_priority_queue.sv */
// self-checking testbench of the min-heap priority queue: directed corner items,
// full and empty rejects, random push/pop mixes against an in-bench heap model
// depends on mhpq_pkg, mhpq_if and min_heap_priority_queue
module tb_min_heap_priority_queue import mhpq_pkg::*;;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst;

  mhpq_req_if req_ch ();
  mhpq_rsp_if rsp_ch ();

  min_heap_priority_queue DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  value_t heap_model [HEAP_DEPTH];
  int     model_count;
  res_t   expected_results [$];
  int     fail_count = 0;
  int     cycle_count = 0;
  bit     no_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // heap model, updated once per accepted request
  task automatic predict_request(input req_type_t kind, input logic [31:0] value);
    res_t    r;
    status_t st;
    int      pos;
    int      up;
    int      child;
    value_t  tmp;
    st = ST_OK;
    if (kind == REQ_PUSH) begin
      if (model_count >= HEAP_DEPTH) begin
        st = ST_FULL;
      end else begin
        pos = model_count;
        heap_model[pos] = value;
        model_count++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_model[up] > heap_model[pos]) begin
            tmp = heap_model[up];
            heap_model[up] = heap_model[pos];
            heap_model[pos] = tmp;
            pos = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (model_count == 0) begin
        st = ST_EMPTY;
      end else begin
        model_count--;
        heap_model[0] = heap_model[model_count];
        pos = 0;
        while (2 * pos + 1 < model_count) begin
          child = 2 * pos + 1;
          if (child + 1 < model_count && heap_model[child + 1] < heap_model[child])
            child++;
          if (heap_model[pos] > heap_model[child]) begin
            tmp = heap_model[pos];
            heap_model[pos] = heap_model[child];
            heap_model[child] = tmp;
            pos = child;
          end else begin
            break;
          end
        end
      end
    end
    r.top_value   = (model_count > 0) ? top_t'(heap_model[0]) : '0;
    r.entry_count = model_count[ENTRY_W-1:0];
    r.is_empty    = (model_count == 0);
    r.status      = st;
    expected_results.push_back(r);
  endtask

  task automatic send_request(input req_type_t kind, input logic [31:0] value);
    int idle;
    idle = no_idle ? 0 : $urandom_range(0, 15);
    if (idle > 0) begin
      req_ch.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.push_value <= value;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    predict_request(kind, value);
    @(negedge clk);
  endtask

  // mix of full-range, near-zero (many ties) and extreme values
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = 32'(int'($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_request(REQ_POP, $urandom);
    send_request(REQ_PUSH, 32'h7fff_ffff);
    send_request(REQ_PUSH, 32'h8000_0000);
    send_request(REQ_PUSH, 32'h0000_0000);
    send_request(REQ_PUSH, 32'hffff_ffff);
    send_request(REQ_PUSH, 32'd5);
    send_request(REQ_PUSH, 32'd5);
    send_request(REQ_PUSH, 32'd5);
    send_request(REQ_PUSH, 32'h8000_0000);
    repeat (8) send_request(REQ_POP, $urandom);
    send_request(REQ_POP, 32'hffff_ffff);
    send_request(REQ_PUSH, 32'h5555_aaaa);
    send_request(REQ_POP, 32'h0000_0000);
  endtask

  task automatic test_fill_and_drain();
    while (model_count < HEAP_DEPTH) send_request(REQ_PUSH, random_value());
    repeat (3) send_request(REQ_PUSH, random_value());
    send_request(REQ_POP, $urandom);
    send_request(REQ_PUSH, random_value());
    send_request(REQ_PUSH, random_value());
    while (model_count > 0) send_request(REQ_POP, $urandom);
    repeat (2) send_request(REQ_POP, $urandom);
  endtask

  task automatic test_random_mix(input int n_items);
    int        push_pct;
    req_type_t kind;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) push_pct = $urandom_range(20, 85);
      kind = ($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP;
      send_request(kind, (kind == REQ_PUSH) ? random_value() : $urandom);
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    no_idle = 1'b1;
    test_random_mix(n_items);
    no_idle = 1'b0;
  endtask

  // response side backpressure
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      int stall;
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result item: top_value %0d entry_count %0d",
               $signed(rsp_ch.top_value), rsp_ch.entry_count);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (rsp_ch.top_value !== exp_r.top_value) begin
          $error("top_value expected %0d actual %0d",
                 $signed(exp_r.top_value), $signed(rsp_ch.top_value));
          fail_count++;
        end
        if (rsp_ch.entry_count !== exp_r.entry_count) begin
          $error("entry_count expected %0d actual %0d", exp_r.entry_count,
                 rsp_ch.entry_count);
          fail_count++;
        end
        if (rsp_ch.is_empty !== exp_r.is_empty) begin
          $error("is_empty expected %0d actual %0d", exp_r.is_empty, rsp_ch.is_empty);
          fail_count++;
        end
        if (rsp_ch.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, rsp_ch.status);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_PUSH;
    req_ch.push_value = '0;
    model_count       = 0;
    no_idle           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_fill_and_drain();
    test_random_mix(380);
    test_back_to_back(120);

    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
